@@ src/psc_pkg.sv @@
// ----------------------------------------------------------------------------
// psc_pkg
// Shared types and constants of the PI speed controller: mode codes, duty
// select codes, register indexes, the duty-map constants and the
// controller-to-datapath command and status groups.
// ----------------------------------------------------------------------------
package psc_pkg;

   // Control modes, as reported on the result channel.
   localparam logic [1:0] MODE_IDLE     = 2'd0;
   localparam logic [1:0] MODE_STARTING = 2'd1;
   localparam logic [1:0] MODE_RUNNING  = 2'd2;
   localparam logic [1:0] MODE_ESTOP    = 2'd3;

   // Source of the duty written into the output register.
   localparam logic [1:0] DSEL_ZERO  = 2'd0;
   localparam logic [1:0] DSEL_START = 2'd1;
   localparam logic [1:0] DSEL_QUOT  = 2'd2;

   // Configuration register port.
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam logic [2:0] REG_KP_GAIN        = 3'd0;
   localparam logic [2:0] REG_KI_GAIN        = 3'd1;
   localparam logic [2:0] REG_INTEGRAL_LIMIT = 3'd2;
   localparam logic [2:0] REG_ERROR_LIMIT    = 3'd3;
   localparam logic [2:0] REG_ESTOP_DECEL    = 3'd4;
   localparam logic [2:0] REG_STOP_DUTY      = 3'd5;
   localparam logic [2:0] REG_STARTUP_DUTY   = 3'd6;
   localparam logic [2:0] REG_OVERSPEED      = 3'd7;

   // Duty map: duty = (6*R*R + 3000*R + 141860000) / 10000000, the bias
   // already holding the half step for rounding. Since 1e7 = 128 * 78125,
   // the numerator is shifted right by 7 and the rest of the division is a
   // multiply by ceil(2^43 / 78125) followed by a shift by 43. That is exact
   // for every shifted numerator below 2^26, which covers all 16-bit targets.
   localparam logic [26:0]        RECIP_MUL   = 27'd112589991;
   localparam int                 RECIP_SHIFT = 43;
   localparam logic signed [34:0] NUM_BIAS    = 35'sd141860000;
   localparam logic signed [12:0] LIN_COEF    = 13'sd3000;

   typedef struct packed {
      logic [3:0]  kp_gain;
      logic [3:0]  ki_gain;
      logic [9:0]  integral_limit;
      logic [11:0] error_limit;
      logic [12:0] estop_decel;
      logic [9:0]  stop_duty;
      logic [9:0]  startup_duty;
      logic [14:0] overspeed_threshold;
   } cfg_type;

   typedef struct packed {
      logic       load;
      logic       check;
      logic       integ;
      logic       gain;
      logic       tgt;
      logic       tgt_estop;
      logic       square;
      logic       numer;
      logic       div_step;
      logic       out_load;
      logic [1:0] duty_sel;
   } cmd_type;

   typedef struct packed {
      logic estop;
      logic over;
      logic below_stop;
   } sts_type;

endpackage

@@ src/psc_regs.sv @@
// ----------------------------------------------------------------------------
// psc_regs
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module psc_regs import psc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [2:0] reg_idx;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[4:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_KP_GAIN:        cfg_in.kp_gain             = csr_pwdata[3:0];
            REG_KI_GAIN:        cfg_in.ki_gain             = csr_pwdata[3:0];
            REG_INTEGRAL_LIMIT: cfg_in.integral_limit      = csr_pwdata[9:0];
            REG_ERROR_LIMIT:    cfg_in.error_limit         = csr_pwdata[11:0];
            REG_ESTOP_DECEL:    cfg_in.estop_decel         = csr_pwdata[12:0];
            REG_STOP_DUTY:      cfg_in.stop_duty           = csr_pwdata[9:0];
            REG_STARTUP_DUTY:   cfg_in.startup_duty        = csr_pwdata[9:0];
            REG_OVERSPEED:      cfg_in.overspeed_threshold = csr_pwdata[14:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_KP_GAIN:        csr_prdata = {28'd0, cfg_ff.kp_gain};
         REG_KI_GAIN:        csr_prdata = {28'd0, cfg_ff.ki_gain};
         REG_INTEGRAL_LIMIT: csr_prdata = {22'd0, cfg_ff.integral_limit};
         REG_ERROR_LIMIT:    csr_prdata = {20'd0, cfg_ff.error_limit};
         REG_ESTOP_DECEL:    csr_prdata = {19'd0, cfg_ff.estop_decel};
         REG_STOP_DUTY:      csr_prdata = {22'd0, cfg_ff.stop_duty};
         REG_STARTUP_DUTY:   csr_prdata = {22'd0, cfg_ff.startup_duty};
         REG_OVERSPEED:      csr_prdata = {17'd0, cfg_ff.overspeed_threshold};
         default:            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.kp_gain             <= 4'd2;
         cfg_ff.ki_gain             <= 4'd1;
         cfg_ff.integral_limit      <= 10'd100;
         cfg_ff.error_limit         <= 12'd500;
         cfg_ff.estop_decel         <= 13'd2000;
         cfg_ff.stop_duty           <= 10'd15;
         cfg_ff.startup_duty        <= 10'd10;
         cfg_ff.overspeed_threshold <= 15'd20000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ src/psc_dp.sv @@
// ----------------------------------------------------------------------------
// psc_dp
// Datapath: error and integral, PI target, duty map with one shared
// squarer and a division by a constant done as a reciprocal multiply.
// ----------------------------------------------------------------------------
module psc_dp import psc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  cmd_type            cmd,
   input  logic signed [15:0] cur_in,
   input  logic [14:0]        des_in,
   input  logic               estop_in,
   output sts_type            sts,
   output logic [9:0]         duty
);

   logic signed [15:0] cur_ff;
   logic [14:0]        des_ff;
   logic               estop_ff;
   logic signed [17:0] err_ff;
   logic               over_ff;
   logic signed [10:0] isum_ff;
   logic signed [10:0] isum_in;
   logic signed [12:0] pe_ff;
   logic signed [17:0] pp_ff;
   logic signed [15:0] ip_ff;
   logic signed [15:0] r_ff;
   logic [31:0]        sq_ff;
   logic signed [27:0] lin_ff;
   logic [25:0]        nq_ff;
   logic [9:0]         quo_ff;
   logic [9:0]         duty_ff;

   logic signed [17:0] err_in;
   logic               over_in;
   logic signed [18:0] isum_sum;
   logic signed [18:0] ilim_pos;
   logic signed [18:0] ilim_neg;
   logic signed [18:0] isum_clamp;
   logic signed [17:0] elim_pos;
   logic signed [17:0] elim_neg;
   logic signed [17:0] pe_clamp;
   logic signed [17:0] pp_in;
   logic signed [15:0] ip_in;
   logic signed [19:0] tgt_sum;
   logic signed [15:0] r_in;
   logic signed [31:0] sq_in;
   logic signed [27:0] lin_in;
   logic signed [34:0] num_in;
   logic [52:0]        prod;

   assign err_in  = $signed({3'b000, des_ff}) - $signed({{2{cur_ff[15]}}, cur_ff});
   assign over_in = $signed({cur_ff[15], cur_ff}) > $signed({2'b00, cfg.overspeed_threshold});

   // Integral accumulate and symmetric clamp.
   assign isum_sum = $signed({{8{isum_ff[10]}}, isum_ff}) + $signed({err_ff[17], err_ff});
   assign ilim_pos = $signed({9'd0, cfg.integral_limit});
   assign ilim_neg = -ilim_pos;

   always_comb begin
      priority if (isum_sum > ilim_pos) begin
         isum_clamp = ilim_pos;
      end else if (isum_sum < ilim_neg) begin
         isum_clamp = ilim_neg;
      end else begin
         isum_clamp = isum_sum;
      end
   end

   assign isum_in  = isum_clamp[10:0];
   assign elim_pos = $signed({6'd0, cfg.error_limit});
   assign elim_neg = -elim_pos;

   always_comb begin
      priority if (err_ff > elim_pos) begin
         pe_clamp = elim_pos;
      end else if (err_ff < elim_neg) begin
         pe_clamp = elim_neg;
      end else begin
         pe_clamp = err_ff;
      end
   end

   assign pp_in = pe_ff * $signed({1'b0, cfg.kp_gain});
   assign ip_in = isum_ff * $signed({1'b0, cfg.ki_gain});

   always_comb begin
      if (cmd.tgt_estop) begin
         tgt_sum = $signed({{4{cur_ff[15]}}, cur_ff}) - $signed({7'd0, cfg.estop_decel});
      end else begin
         tgt_sum = $signed({{4{cur_ff[15]}}, cur_ff}) + $signed({{2{pp_ff[17]}}, pp_ff})
                 + $signed({{4{ip_ff[15]}}, ip_ff});
      end
      priority if (tgt_sum > 20'sd32767) begin
         r_in = 16'sh7FFF;
      end else if (tgt_sum < -20'sd32768) begin
         r_in = 16'sh8000;
      end else begin
         r_in = tgt_sum[15:0];
      end
   end

   assign sq_in  = r_ff * r_ff;
   assign lin_in = r_ff * LIN_COEF;
   assign num_in = $signed({1'b0, sq_ff, 2'b00}) + $signed({2'b00, sq_ff, 1'b0})
                 + $signed({{7{lin_ff[27]}}, lin_ff}) + NUM_BIAS;

   // The numerator is always positive and below 2^33, so after the shift by
   // 7 it fits 26 bits; the quotient is the top ten bits of the product.
   assign prod = nq_ff * RECIP_MUL;

   assign sts.estop      = estop_ff;
   assign sts.over       = over_ff;
   assign sts.below_stop = quo_ff < cfg.stop_duty;
   assign duty           = duty_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         isum_ff <= '0;
      end else if (cmd.integ) begin
         isum_ff <= isum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cur_ff   <= cur_in;
         des_ff   <= des_in;
         estop_ff <= estop_in;
      end
      if (cmd.check) begin
         err_ff  <= err_in;
         over_ff <= over_in;
      end
      if (cmd.integ) begin
         pe_ff <= pe_clamp[12:0];
      end
      if (cmd.gain) begin
         pp_ff <= pp_in;
         ip_ff <= ip_in;
      end
      if (cmd.tgt) begin
         r_ff <= r_in;
      end
      if (cmd.square) begin
         sq_ff  <= sq_in;
         lin_ff <= lin_in;
      end
      if (cmd.numer) begin
         nq_ff <= num_in[32:7];
      end
      if (cmd.div_step) begin
         quo_ff <= prod[RECIP_SHIFT +: 10];
      end
      if (cmd.out_load) begin
         unique case (cmd.duty_sel)
            DSEL_ZERO:  duty_ff <= '0;
            DSEL_START: duty_ff <= cfg.startup_duty;
            DSEL_QUOT:  duty_ff <= quo_ff;
            default:    duty_ff <= '0;
         endcase
      end
   end

endmodule

@@ src/psc_ctrl.sv @@
// ----------------------------------------------------------------------------
// psc_ctrl
// Controller: sequences one tick through the datapath, keeps the control
// mode and holds the result handshake.
// ----------------------------------------------------------------------------
module psc_ctrl import psc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_motor_enable,
   output logic [1:0] rsp_mode,
   input  sts_type    sts,
   output cmd_type    cmd
);

   localparam logic [3:0] ST_WAIT  = 4'd0;
   localparam logic [3:0] ST_CHECK = 4'd1;
   localparam logic [3:0] ST_MODE  = 4'd2;
   localparam logic [3:0] ST_INTEG = 4'd3;
   localparam logic [3:0] ST_GAIN  = 4'd4;
   localparam logic [3:0] ST_TGT   = 4'd5;
   localparam logic [3:0] ST_SQ    = 4'd6;
   localparam logic [3:0] ST_NUM   = 4'd7;
   localparam logic [3:0] ST_DIV   = 4'd8;
   localparam logic [3:0] ST_FIN   = 4'd9;

   logic [3:0] state_ff, state_in;
   logic [1:0] mode_ff, mode_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_en_ff, rsp_en_in;
   logic [1:0] rsp_mode_ff, rsp_mode_in;
   logic [1:0] eff_mode;

   assign req_ready        = (state_ff == ST_WAIT);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_motor_enable = rsp_en_ff;
   assign rsp_mode         = rsp_mode_ff;
   assign eff_mode         = (sts.estop || sts.over) ? MODE_ESTOP : mode_ff;

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_en_in    = rsp_en_ff;
      rsp_mode_in  = rsp_mode_ff;
      cmd          = '0;
      unique case (state_ff)
         ST_WAIT: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            state_in  = ST_MODE;
         end
         ST_MODE: begin
            mode_in = eff_mode;
            unique case (eff_mode)
               MODE_RUNNING: state_in = ST_INTEG;
               MODE_ESTOP:   state_in = ST_TGT;
               default:      state_in = ST_FIN;
            endcase
         end
         ST_INTEG: begin
            cmd.integ = 1'b1;
            state_in  = ST_GAIN;
         end
         ST_GAIN: begin
            cmd.gain = 1'b1;
            state_in = ST_TGT;
         end
         ST_TGT: begin
            cmd.tgt       = 1'b1;
            cmd.tgt_estop = (mode_ff == MODE_ESTOP);
            state_in      = ST_SQ;
         end
         ST_SQ: begin
            cmd.square = 1'b1;
            state_in   = ST_NUM;
         end
         ST_NUM: begin
            cmd.numer = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            state_in     = ST_FIN;
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_WAIT;
               unique case (mode_ff)
                  MODE_IDLE: begin
                     cmd.duty_sel = DSEL_ZERO;
                     rsp_en_in    = 1'b0;
                  end
                  MODE_STARTING: begin
                     cmd.duty_sel = DSEL_START;
                     rsp_en_in    = 1'b1;
                     mode_in      = MODE_RUNNING;
                  end
                  MODE_RUNNING: begin
                     cmd.duty_sel = DSEL_QUOT;
                     rsp_en_in    = 1'b1;
                  end
                  MODE_ESTOP: begin
                     if (sts.below_stop) begin
                        cmd.duty_sel = DSEL_ZERO;
                        rsp_en_in    = 1'b0;
                        mode_in      = MODE_IDLE;
                     end else begin
                        cmd.duty_sel = DSEL_QUOT;
                        rsp_en_in    = 1'b1;
                     end
                  end
                  default: begin
                     cmd.duty_sel = DSEL_ZERO;
                     rsp_en_in    = 1'b0;
                  end
               endcase
               rsp_mode_in = mode_in;
            end
         end
         default: begin
            state_in = ST_WAIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_WAIT;
         mode_ff      <= MODE_STARTING;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_en_ff   <= rsp_en_in;
      rsp_mode_ff <= rsp_mode_in;
   end

endmodule

@@ src/pi_speed_controller_with_estop.sv @@
// ----------------------------------------------------------------------------
// pi_speed_controller_with_estop
// PI motor speed controller with emergency stop: one control tick in, one
// PWM duty, enable bit and mode out.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake                      Payload
//   req_      in         req_valid / req_ready          meas_speed, set_speed,
//                                                       estop_request
//   rsp_      out        rsp_valid / rsp_ready          duty, motor_enable, mode
//   csr_      in/out     psel, penable, pwrite, pready  paddr, pwdata, prdata
//
// An idle or starting tick goes from the mode step straight to the final
// step; a running tick first passes the integral, gain, target, square,
// numerator and reciprocal-multiply steps, an emergency-stopping tick all
// but the first two. The next item can be taken as the result turns valid.
// Reset is synchronous and active high; it restores the register defaults,
// sets the mode to starting and clears the integral.
// The block accepts a new item while the previous result still waits in the
// output register; if that result is still not taken when the next one is
// finished, the controller holds in its final step until it is.
// ----------------------------------------------------------------------------
module pi_speed_controller_with_estop import psc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic signed [15:0]    req_meas_speed,
   input  logic [14:0]           req_set_speed,
   input  logic                  req_estop_request,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [9:0]            rsp_duty,
   output logic                  rsp_motor_enable,
   output logic [1:0]            rsp_mode,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type cfg;
   cmd_type cmd;
   sts_type sts;

   // Configuration registers; writes are only expected while the block is idle.
   psc_regs u_regs (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // The controller owns the mode and the result handshake; it steps the
   // datapath: error, integral, gains, target, square, numerator, divide.
   psc_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_motor_enable (rsp_motor_enable),
      .rsp_mode         (rsp_mode),
      .sts              (sts),
      .cmd              (cmd)
   );

   // The datapath holds the captured item, the integral and the duty register.
   psc_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .cmd      (cmd),
      .cur_in   (req_meas_speed),
      .des_in   (req_set_speed),
      .estop_in (req_estop_request),
      .sts      (sts),
      .duty     (rsp_duty)
   );

`ifndef SYNTHESIS
   // A disabled drive always reports zero duty.
   a_disabled_zero_duty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_motor_enable) |-> (rsp_duty == 10'd0))
      else $error("disabled result with nonzero duty");

   // Idle mode is only ever reported with the drive disabled.
   a_idle_disabled: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_mode == MODE_IDLE)) |-> !rsp_motor_enable)
      else $error("idle result with drive enabled");

   // Starting never reaches a result: it becomes running, or stopping on a stop.
   a_no_starting_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_mode != MODE_STARTING))
      else $error("result reports starting mode");

   // After an item is taken, the block is busy on the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input accepted back to back");
`endif

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the PI speed controller with emergency stop. A
// table of hand-picked control ticks and then random ticks drive the request
// channel. A software copy of the controller predicts every result that the
// table does not give, and each returned item is checked field by field. Both
// channels stall at random, and all the registers are rewritten between
// phases over the register port and read back.
// ----------------------------------------------------------------------------
module tb;
   import psc_pkg::*;

   // There are about 900 items, so even with both sides stalling this limit
   // leaves a wide margin.
   localparam int     CYCLE_LIMIT  = 400000;
   localparam int     RUN_ROWS     = 10;
   localparam int     TABLE_ROWS   = 21;
   localparam int     TAIL_CYCLES  = 40;
   localparam longint DUTY_OFFSET  = 141860000;
   localparam longint DUTY_DIVISOR = 10000000;

   typedef struct packed {
      logic [9:0] duty;
      logic       motor_enable;
      logic [1:0] mode;
   } drive_type;

   // One directed tick. When typed is set, want is the result read straight
   // off the controller's behavior; otherwise the software copy supplies it.
   typedef struct packed {
      logic signed [15:0] speed;
      logic [14:0]        target;
      logic               stop;
      logic               typed;
      drive_type          want;
   } tick_row_type;

   typedef enum {SET_RESET, SET_MAX, SET_ZERO, SET_RANDOM} setting_kind_type;

   localparam cfg_type RESET_CFG = '{
      kp_gain: 4'd2, ki_gain: 4'd1, integral_limit: 10'd100, error_limit: 12'd500,
      estop_decel: 13'd2000, stop_duty: 10'd15, startup_duty: 10'd10,
      overspeed_threshold: 15'd20000
   };

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic signed [15:0]    req_meas_speed = '0;
   logic [14:0]           req_set_speed = '0;
   logic                  req_estop_request = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [9:0]            rsp_duty;
   logic                  rsp_motor_enable;
   logic [1:0]            rsp_mode;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // Software copy of the controller: registers, mode and integral.
   cfg_type    ctl_cfg = RESET_CFG;
   logic [1:0] mode_now = MODE_STARTING;
   int         integ_now = 0;

   drive_type pending_drive [$];
   drive_type oldest_drive;
   int        fail_count = 0;
   int        cycle_count = 0;
   int        gap_pct = 0;
   int        stall_pct = 0;
   int        stall_left = 0;

   // The controller never returns to running from idle or stopping without a
   // reset, so the table is walked in two pieces: the running ticks first, and
   // the stopping ticks only after all the random running phases are done.
   tick_row_type tick_rows [0:TABLE_ROWS-1] = '{
      // First tick after reset: startup duty, then the mode moves to running.
      '{16'sd0, 15'd0, 1'b0, 1'b1, '{10'd10, 1'b1, MODE_RUNNING}},
      // Zero error and zero integral leave a target of zero, duty 14.
      '{16'sd0, 15'd0, 1'b0, 1'b1, '{10'd14, 1'b1, MODE_RUNNING}},
      '{16'sd0, 15'd20000, 1'b0, 1'b0, '0},
      '{16'sd0, 15'd32767, 1'b0, 1'b0, '0},
      // A speed equal to the threshold is not overspeed.
      '{16'sd20000, 15'd0, 1'b0, 1'b0, '0},
      // Negative speeds never count as overspeed.
      '{-16'sd20000, 15'd20000, 1'b0, 1'b0, '0},
      '{16'sh8000, 15'd32767, 1'b0, 1'b0, '0},
      '{16'sh2AAA, 15'h5555, 1'b0, 1'b0, '0},
      '{16'shD555, 15'h2AAA, 1'b0, 1'b0, '0},
      '{16'sd100, 15'd100, 1'b0, 1'b0, '0},
      // Stop request while running; the stopping duty stays at the threshold.
      '{16'sd0, 15'd0, 1'b1, 1'b0, '0},
      // Stopping holds without a request while the duty stays high.
      '{16'sd20000, 15'd0, 1'b0, 1'b0, '0},
      // Target of -250 maps to duty 14, under the threshold: motor off.
      '{16'sd1750, 15'd0, 1'b0, 1'b0, '0},
      '{16'sd0, 15'd100, 1'b0, 1'b1, '{10'd0, 1'b0, MODE_IDLE}},
      '{16'sh8000, 15'd32767, 1'b0, 1'b1, '{10'd0, 1'b0, MODE_IDLE}},
      '{16'sd20000, 15'd0, 1'b0, 1'b1, '{10'd0, 1'b0, MODE_IDLE}},
      // Overspeed out of idle enters stopping on the same tick.
      '{16'sd20001, 15'd0, 1'b0, 1'b0, '0},
      '{16'sd1750, 15'd0, 1'b1, 1'b0, '0},
      // Stop request out of idle that drops straight back to idle.
      '{16'sd1750, 15'd0, 1'b1, 1'b0, '0},
      '{16'sd32767, 15'd32767, 1'b1, 1'b0, '0},
      '{16'sd1750, 15'd0, 1'b0, 1'b0, '0}
   };

   pi_speed_controller_with_estop dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_meas_speed    (req_meas_speed),
      .req_set_speed     (req_set_speed),
      .req_estop_request (req_estop_request),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_duty          (rsp_duty),
      .rsp_motor_enable  (rsp_motor_enable),
      .rsp_mode          (rsp_mode),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   always #2 clock = ~clock;

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------

   function automatic int clamp_sym(input int v, input int lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
   endfunction

   function automatic int sat16(input int v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   // Quadratic fit from a speed target to a PWM duty, rounded half up. The
   // numerator is positive for every 16-bit target, so plain division works.
   function automatic logic [9:0] duty_of(input int target);
      longint r;
      r = target;
      return 10'((6 * r * r + 3000 * r + DUTY_OFFSET) / DUTY_DIVISOR);
   endfunction

   // Advances the software controller by one tick and returns its output.
   function automatic drive_type compute_drive(input logic signed [15:0] speed,
                                               input logic [14:0] target,
                                               input logic stop);
      drive_type  d;
      int         spd;
      int         err;
      int         tgt;
      logic [9:0] mapped;
      d = '0;
      spd = speed;
      // A request or overspeed overrides every mode, idle included.
      if (stop || spd > int'(ctl_cfg.overspeed_threshold)) mode_now = MODE_ESTOP;
      case (mode_now)
         MODE_STARTING: begin
            d.duty = ctl_cfg.startup_duty;
            d.motor_enable = 1'b1;
            mode_now = MODE_RUNNING;
         end
         MODE_RUNNING: begin
            err = int'(target) - spd;
            integ_now = clamp_sym(integ_now + err, int'(ctl_cfg.integral_limit));
            tgt = spd + int'(ctl_cfg.kp_gain) * clamp_sym(err, int'(ctl_cfg.error_limit))
                  + int'(ctl_cfg.ki_gain) * integ_now;
            d.duty = duty_of(sat16(tgt));
            d.motor_enable = 1'b1;
         end
         MODE_ESTOP: begin
            mapped = duty_of(sat16(spd - int'(ctl_cfg.estop_decel)));
            if (mapped < ctl_cfg.stop_duty) begin
               mode_now = MODE_IDLE;
            end else begin
               d.duty = mapped;
               d.motor_enable = 1'b1;
            end
         end
         default: mode_now = MODE_IDLE;
      endcase
      d.mode = mode_now;
      return d;
   endfunction

   function automatic int pick(input int lo, input int hi);
      return lo + int'($urandom_range(0, hi - lo));
   endfunction

   // ------------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------------

   // Offers one tick and records its expected result once it is accepted.
   // An idle gap, when one is drawn, comes before the tick, so valid is never
   // lowered and raised again within one step.
   task automatic send_tick(input logic signed [15:0] speed, input logic [14:0] target,
                            input logic stop, input logic typed, input drive_type typed_drive);
      drive_type want;
      if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_meas_speed <= speed;
      req_set_speed <= target;
      req_estop_request <= stop;
      do @(posedge clock); while (!req_ready);
      want = compute_drive(speed, target, stop);
      if (typed) want = typed_drive;
      pending_drive.push_back(want);
   endtask

   // Random ticks that keep the controller in running mode: no stop requests
   // and no speed above the current threshold. A third of the ticks ask for a
   // speed close to the measured one so the integral does not just saturate.
   task automatic drive_running(input int count);
      int top;
      int spd;
      int des;
      top = ctl_cfg.overspeed_threshold;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 3) == 0) spd = pick(-32768, top);
         else spd = pick(-20000, (top < 20000) ? top : 20000);
         case ($urandom_range(0, 2))
            0: des = pick(0, 32767);
            1: begin
               des = spd + pick(-300, 300);
               if (des < 0) des = 0;
               if (des > 32767) des = 32767;
            end
            default: des = pick(0, 20000);
         endcase
         send_tick(16'(spd), 15'(des), 1'b0, 1'b0, '0);
      end
   endtask

   // Random ticks once the controller has stopped: requests, overspeed and
   // speeds whose stopping duty lies near the low end of the duty curve, so
   // the mode keeps moving between idle and emergency stopping.
   task automatic drive_stopping(input int count);
      int top;
      int spd;
      top = ctl_cfg.overspeed_threshold;
      for (int n = 0; n < count; n++) begin
         case ($urandom_range(0, 2))
            0: spd = (top < 32767) ? pick(top + 1, 32767) : pick(-32768, 32767);
            1: spd = int'(ctl_cfg.estop_decel) - 250 + pick(-800, 800);
            default: spd = pick(-32768, 32767);
         endcase
         send_tick(16'(spd), 15'(pick(0, 32767)), $urandom_range(0, 4) == 0, 1'b0, '0);
      end
   endtask

   // Stops offering ticks and waits until every expected result is back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_drive.size() != 0) @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Register port
   // ------------------------------------------------------------------------

   // Setup, then access until pready. The select is left high so that a
   // following access can start in the same step without a second update.
   task automatic csr_access(input logic [2:0] idx, input logic wr, input logic [31:0] value);
      logic [31:0] image;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= wr;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (wr) begin
         case (idx)
            REG_KP_GAIN:        ctl_cfg.kp_gain = value[3:0];
            REG_KI_GAIN:        ctl_cfg.ki_gain = value[3:0];
            REG_INTEGRAL_LIMIT: ctl_cfg.integral_limit = value[9:0];
            REG_ERROR_LIMIT:    ctl_cfg.error_limit = value[11:0];
            REG_ESTOP_DECEL:    ctl_cfg.estop_decel = value[12:0];
            REG_STOP_DUTY:      ctl_cfg.stop_duty = value[9:0];
            REG_STARTUP_DUTY:   ctl_cfg.startup_duty = value[9:0];
            default:            ctl_cfg.overspeed_threshold = value[14:0];
         endcase
      end else begin
         case (idx)
            REG_KP_GAIN:        image = 32'(ctl_cfg.kp_gain);
            REG_KI_GAIN:        image = 32'(ctl_cfg.ki_gain);
            REG_INTEGRAL_LIMIT: image = 32'(ctl_cfg.integral_limit);
            REG_ERROR_LIMIT:    image = 32'(ctl_cfg.error_limit);
            REG_ESTOP_DECEL:    image = 32'(ctl_cfg.estop_decel);
            REG_STOP_DUTY:      image = 32'(ctl_cfg.stop_duty);
            REG_STARTUP_DUTY:   image = 32'(ctl_cfg.startup_duty);
            default:            image = 32'(ctl_cfg.overspeed_threshold);
         endcase
         if (csr_prdata !== image) begin
            $display("%0t: register %0d read expected %0h, actual %0h",
                     $time, idx, image, csr_prdata);
            fail_count++;
         end
      end
   endtask

   // Drains the block, writes every register, reads them all back and draws
   // a new idling mix for the phase that follows. The random words carry
   // junk above each register's width on purpose.
   task automatic reconfigure(input setting_kind_type kind);
      logic [31:0] word;
      wait_drained();
      for (int i = REG_KP_GAIN; i <= REG_OVERSPEED; i++) begin
         case (kind)
            SET_MAX:    word = '1;
            SET_ZERO:   word = '0;
            SET_RANDOM: word = $urandom();
            default: begin
               case (3'(i))
                  REG_KP_GAIN:        word = 32'(RESET_CFG.kp_gain);
                  REG_KI_GAIN:        word = 32'(RESET_CFG.ki_gain);
                  REG_INTEGRAL_LIMIT: word = 32'(RESET_CFG.integral_limit);
                  REG_ERROR_LIMIT:    word = 32'(RESET_CFG.error_limit);
                  REG_ESTOP_DECEL:    word = 32'(RESET_CFG.estop_decel);
                  REG_STOP_DUTY:      word = 32'(RESET_CFG.stop_duty);
                  REG_STARTUP_DUTY:   word = 32'(RESET_CFG.startup_duty);
                  default:            word = 32'(RESET_CFG.overspeed_threshold);
               endcase
            end
         endcase
         csr_access(3'(i), 1'b1, word);
      end
      for (int i = REG_KP_GAIN; i <= REG_OVERSPEED; i++) csr_access(3'(i), 1'b0, '0);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      gap_pct = 15 * $urandom_range(0, 3);
      stall_pct = 15 * $urandom_range(0, 3);
   endtask

   // ------------------------------------------------------------------------
   // Result side
   // ------------------------------------------------------------------------

   // The receiver stalls in bursts; stall_pct sets how often a burst starts,
   // and zero gives stretches with no stalls at all.
   always @(posedge clock) begin
      if (stall_left > 1) begin
         stall_left <= stall_left - 1;
      end else if (stall_left == 1) begin
         stall_left <= 0;
         rsp_ready <= 1'b1;
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
         stall_left <= $urandom_range(1, 8);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Every accepted result is compared with the oldest expected one.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_drive.size() == 0) begin
            $display("%0t: result with none expected, actual duty %0d enable %0b mode %0d",
                     $time, rsp_duty, rsp_motor_enable, rsp_mode);
            fail_count++;
         end else begin
            oldest_drive = pending_drive.pop_front();
            if (rsp_duty !== oldest_drive.duty) begin
               $display("%0t: duty expected %0d, actual %0d",
                        $time, oldest_drive.duty, rsp_duty);
               fail_count++;
            end
            if (rsp_motor_enable !== oldest_drive.motor_enable) begin
               $display("%0t: motor_enable expected %0b, actual %0b",
                        $time, oldest_drive.motor_enable, rsp_motor_enable);
               fail_count++;
            end
            if (rsp_mode !== oldest_drive.mode) begin
               $display("%0t: mode expected %0d, actual %0d",
                        $time, oldest_drive.mode, rsp_mode);
               fail_count++;
            end
         end
      end
   end

   // Watchdog against a hung handshake.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[pi_speed_controller_with_estop] ERROR");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------------

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      gap_pct = 15 * $urandom_range(0, 3);
      stall_pct = 15 * $urandom_range(0, 3);

      // Directed running ticks with the reset register values.
      for (int i = 0; i < RUN_ROWS; i++) begin
         send_tick(tick_rows[i].speed, tick_rows[i].target, tick_rows[i].stop,
                   tick_rows[i].typed, tick_rows[i].want);
      end

      // Random running ticks under the reset values, the largest values, all
      // zeros (zero limits clamp error and integral to nothing and a zero
      // threshold keeps speeds at or below zero), then random settings.
      drive_running(80);
      reconfigure(SET_MAX);
      drive_running(80);
      reconfigure(SET_ZERO);
      drive_running(80);
      for (int k = 0; k < 4; k++) begin
         reconfigure(SET_RANDOM);
         drive_running(80);
      end

      // Directed stopping ticks, back on the reset values that their typed
      // results assume.
      reconfigure(SET_RESET);
      for (int i = RUN_ROWS; i < TABLE_ROWS; i++) begin
         send_tick(tick_rows[i].speed, tick_rows[i].target, tick_rows[i].stop,
                   tick_rows[i].typed, tick_rows[i].want);
      end

      // Random stopping and idle ticks; the last phase runs without stalls.
      drive_stopping(100);
      reconfigure(SET_RANDOM);
      drive_stopping(100);
      reconfigure(SET_RANDOM);
      gap_pct = 0;
      stall_pct = 0;
      drive_stopping(100);

      // Drain, then leave room for any stray result to show up.
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("[pi_speed_controller_with_estop] OK");
      end else begin
         $display("[pi_speed_controller_with_estop] ERROR");
      end
      $finish;
   end

endmodule
